// ----- rtl/ordered_key_neighbor_lookup_defines.svh -----
// Assertion macros used by the checker of the neighbor lookup block.
`ifndef ORDERED_KEY_NEIGHBOR_LOOKUP_DEFINES_SVH
`define ORDERED_KEY_NEIGHBOR_LOOKUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OKN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OKN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/okn_pkg.sv -----
package okn_pkg;

    localparam int KEY_W = 32;

    localparam logic signed [KEY_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Query token that walks down the cell chain with its running best values.
    typedef struct packed {
        logic                    vld;
        logic signed [KEY_W-1:0] qkey;
        logic signed [KEY_W-1:0] best_lo;
        logic                    lo_found;
        logic signed [KEY_W-1:0] best_hi;
        logic                    hi_found;
    } t_token;

endpackage

// ----- rtl/ordered_key_neighbor_lookup.sv -----
// Ordered key neighbor lookup. The block keeps up to CAPACITY signed 32-bit keys
// (duplicates kept) and answers neighbor queries. A request is taken at a rising
// edge with start high and busy low; every request gives exactly one result,
// shown for one cycle with o_valid high, and the receiver cannot stall it, so it
// must take each result in that cycle. An insert (opcode 0) returns its result in
// the cycle after it is taken and busy stays low, so inserts can follow each
// other every cycle; an insert into a full store is dropped and o_insert_dropped
// is set. A query (opcode 1) holds busy high while its token walks the chain
// of key cells, one cell per cycle, and its result appears in the first cycle
// in which busy is low again. The answer is the greatest stored key strictly
// below the query key and the least stored key strictly above it; when there is
// none, the key reads -2^31 or 2^31-1 with its found flag low. Insert results
// always carry the no-neighbor values on the key outputs.
module ordered_key_neighbor_lookup #(
    parameter int CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_opcode,
    input  logic signed [okn_pkg::KEY_W-1:0] i_key,
    output logic                             o_valid,
    output logic signed [okn_pkg::KEY_W-1:0] o_pred_key,
    output logic                             o_pred_found,
    output logic signed [okn_pkg::KEY_W-1:0] o_succ_key,
    output logic                             o_succ_found,
    output logic                             o_insert_dropped
);
    import okn_pkg::*;

    // The count must be able to hold CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]           r_count;
    logic                    r_busy;
    logic                    r_valid;
    logic signed [KEY_W-1:0] r_pred_key;
    logic                    r_pred_found;
    logic signed [KEY_W-1:0] r_succ_key;
    logic                    r_succ_found;
    logic                    r_dropped;

    logic w_accept;
    logic w_insert;
    logic w_query;
    logic w_full;

    // Token links between the cells: entry 0 feeds the first cell, the last
    // entry is what leaves the chain.
    t_token w_tok [CAPACITY+1];
    logic   w_we  [CAPACITY];
    logic   w_occ [CAPACITY];

    assign w_accept = start && !r_busy;
    assign w_insert = w_accept && (i_opcode == OP_INSERT);
    assign w_query  = w_accept && (i_opcode == OP_QUERY);
    assign w_full   = (r_count == CW'(CAPACITY));

    // A query enters with fresh running best values.
    assign w_tok[0] = '{vld: w_query, qkey: i_key, best_lo: INT_MIN, lo_found: 1'b0,
                        best_hi: INT_MAX, hi_found: 1'b0};

    // Keys fill the cells in order, so cell i holds a key exactly when the
    // count is above i. The count never moves while a query is in the chain.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_we[g]  = w_insert && !w_full && (r_count == CW'(g));
        assign w_occ[g] = (r_count > CW'(g));

        okn_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_we       (w_we[g]),
            .i_key      (i_key),
            .i_occupied (w_occ[g]),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (w_insert) begin
                r_valid <= 1'b1;
                if (!w_full) begin
                    r_count <= r_count + CW'(1);
                end
            end else if (w_query) begin
                r_busy <= 1'b1;
            end
            if (w_tok[CAPACITY].vld) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    // Result payload. An insert and a finished query never land on the same
    // edge, because no request is taken while a query is in the chain.
    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_pred_key   <= INT_MIN;
            r_pred_found <= 1'b0;
            r_succ_key   <= INT_MAX;
            r_succ_found <= 1'b0;
            r_dropped    <= w_full;
        end else if (w_tok[CAPACITY].vld) begin
            r_pred_key   <= w_tok[CAPACITY].best_lo;
            r_pred_found <= w_tok[CAPACITY].lo_found;
            r_succ_key   <= w_tok[CAPACITY].best_hi;
            r_succ_found <= w_tok[CAPACITY].hi_found;
            r_dropped    <= 1'b0;
        end
    end

    assign busy             = r_busy;
    assign o_valid          = r_valid;
    assign o_pred_key       = r_pred_key;
    assign o_pred_found     = r_pred_found;
    assign o_succ_key       = r_succ_key;
    assign o_succ_found     = r_succ_found;
    assign o_insert_dropped = r_dropped;

endmodule

// ----- rtl/okn_cell.sv -----
module okn_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic signed [okn_pkg::KEY_W-1:0] i_key,
    input  logic                            i_occupied,
    input  okn_pkg::t_token                 i_tok,
    output okn_pkg::t_token                 o_tok
);
    import okn_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    t_token                  r_tok;
    t_token                  n_tok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key <= i_key;
        end
    end

    // A cell only weighs in when it holds a written key.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && i_occupied) begin
            if (($signed(r_key) < $signed(i_tok.qkey)) &&
                (!i_tok.lo_found || ($signed(r_key) > $signed(i_tok.best_lo)))) begin
                n_tok.best_lo  = r_key;
                n_tok.lo_found = 1'b1;
            end
            if (($signed(r_key) > $signed(i_tok.qkey)) &&
                (!i_tok.hi_found || ($signed(r_key) < $signed(i_tok.best_hi)))) begin
                n_tok.best_hi  = r_key;
                n_tok.hi_found = 1'b1;
            end
        end
    end

    // Only the valid bit needs a reset; the payload follows it unreset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.qkey     <= n_tok.qkey;
        r_tok.best_lo  <= n_tok.best_lo;
        r_tok.lo_found <= n_tok.lo_found;
        r_tok.best_hi  <= n_tok.best_hi;
        r_tok.hi_found <= n_tok.hi_found;
    end

    assign o_tok = r_tok;

endmodule

// ----- rtl/okn_checker.sv -----
`include "ordered_key_neighbor_lookup_defines.svh"

module okn_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             i_opcode,
    input logic                             o_valid,
    input logic signed [okn_pkg::KEY_W-1:0] o_pred_key,
    input logic                             o_pred_found,
    input logic signed [okn_pkg::KEY_W-1:0] o_succ_key,
    input logic                             o_succ_found,
    input logic                             o_insert_dropped
);
    import okn_pkg::*;

    // A taken query occupies the block right away.
    `OKN_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && (i_opcode == OP_QUERY), busy, "query request did not raise busy")
    // An insert answers in the next cycle.
    `OKN_ASSERT_NEXT(a_insert_result, i_clk, i_rst_n, start && !busy && (i_opcode == OP_INSERT), o_valid, "insert request gave no result")
    // The end of a query walk shows its result.
    `OKN_ASSERT_NOW(a_query_result, i_clk, i_rst_n, $fell(busy), o_valid, "query finished without a result")
    // Both neighbors found means they are ordered.
    `OKN_ASSERT_NOW(a_order, i_clk, i_rst_n, o_valid && o_pred_found && o_succ_found, $signed(o_pred_key) < $signed(o_succ_key), "predecessor not below successor")
    // A dropped insert carries no neighbors.
    `OKN_ASSERT_NOW(a_drop_clean, i_clk, i_rst_n, o_valid && o_insert_dropped, !o_pred_found && !o_succ_found, "dropped insert reports a neighbor")

endmodule

bind ordered_key_neighbor_lookup okn_checker u_okn_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_opcode         (i_opcode),
    .o_valid          (o_valid),
    .o_pred_key       (o_pred_key),
    .o_pred_found     (o_pred_found),
    .o_succ_key       (o_succ_key),
    .o_succ_found     (o_succ_found),
    .o_insert_dropped (o_insert_dropped)
);
